>>> rtl/bmpq_pkg.sv
// ----------------------------------------------------------------------------
// bmpq_pkg
// Shared constants and types of the bounded max priority queue: sizes,
// operation codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpq_pkg;

	localparam int DEPTH     = 16;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int DATA_W    = 16;
	localparam int MODE_W    = 2;
	localparam int OUT_CNT_W = 5;
	// count widened so that the low OUT_CNT_W bits can always be selected
	localparam int CNT_EXT_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] prio;
		logic [DATA_W-1:0] tag;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;       // item taken this cycle
		logic ins;          // write new entry at the tail
		logic reject;       // insert into a full queue
		logic clr;          // drop all entries
		logic shift_start;  // begin closing the gap left by the head
		logic shift;        // shift pass running
		logic shift_end;    // shift pass finished, count drops by one
		logic scan;         // head search running
		logic load_out;     // capture the result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic shift_done;
		logic scan_done;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/bmpq_ctrl.sv
// ----------------------------------------------------------------------------
// bmpq_ctrl
// Controller of the priority queue: sequences insert, remove, clear and
// query items and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpq_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [bmpq_pkg::MODE_W-1:0]   mode,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	input  wire bmpq_pkg::status_t             status,
	output bmpq_pkg::cmd_t                     cmd
);

	bmpq_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != bmpq_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmpq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			bmpq_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = bmpq_pkg::ST_DONE;
					unique case (bmpq_pkg::mode_t'(mode))
						bmpq_pkg::MODE_INSERT: begin
							cmd.ins    = !status.full;
							cmd.reject = status.full;
						end
						bmpq_pkg::MODE_REMOVE: begin
							if (!status.empty) begin
								cmd.shift_start = 1'b1;
								state_d         = bmpq_pkg::ST_SHIFT;
							end
						end
						bmpq_pkg::MODE_CLEAR: cmd.clr = 1'b1;
						bmpq_pkg::MODE_QUERY: ;
						default: ;
					endcase
				end
			end
			bmpq_pkg::ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (status.shift_done) begin
					cmd.shift_end = 1'b1;
					state_d       = bmpq_pkg::ST_SCAN;
				end
			end
			bmpq_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done)
					state_d = bmpq_pkg::ST_DONE;
			end
			bmpq_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = bmpq_pkg::ST_IDLE;
				end
			end
			default: state_d = bmpq_pkg::ST_IDLE;
		endcase
	end

	// a finished result never overwrites one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !cmd.load_out)
		else $error("result loaded over a stalled result");

	// every accepted item yields a result before the next item is taken
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> state_q == bmpq_pkg::ST_IDLE && out_valid_q)
		else $error("result load did not return to idle");

	// removal from a non-empty queue always runs the shift pass
	a_remove_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_start |=> state_q == bmpq_pkg::ST_SHIFT)
		else $error("remove did not enter the shift pass");

endmodule

`default_nettype wire

>>> rtl/bmpq_dp.sv
// ----------------------------------------------------------------------------
// bmpq_dp
// Datapath of the priority queue: entry memory in arrival order, entry
// count, cached head, shift/scan pointer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpq_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [bmpq_pkg::DATA_W-1:0]        priority_req,
	input  wire logic [bmpq_pkg::DATA_W-1:0]        tag,
	input  wire bmpq_pkg::cmd_t                     cmd,
	output bmpq_pkg::status_t                       status,
	output logic      [bmpq_pkg::DATA_W-1:0]        head_tag,
	output logic      [bmpq_pkg::DATA_W-1:0]        head_priority,
	output logic                                    is_empty,
	output logic      [bmpq_pkg::OUT_CNT_W-1:0]     entry_count,
	output logic                                    rejected
);

	bmpq_pkg::entry_t mem [bmpq_pkg::DEPTH];
	bmpq_pkg::entry_t rd_data_q;

	logic [bmpq_pkg::CNT_W-1:0]     count_q;
	logic [bmpq_pkg::CNT_W-1:0]     ptr_q;
	logic [bmpq_pkg::IDX_W-1:0]     head_idx_q;
	logic [bmpq_pkg::DATA_W-1:0]    head_prio_q;
	logic [bmpq_pkg::DATA_W-1:0]    head_tag_q;
	logic                           wr_pend_q;
	logic [bmpq_pkg::IDX_W-1:0]     wr_addr_q;
	logic                           cmp_pend_q;
	logic [bmpq_pkg::IDX_W-1:0]     cmp_idx_q;
	logic                           rej_q;

	logic [bmpq_pkg::DATA_W-1:0]    out_tag_q;
	logic [bmpq_pkg::DATA_W-1:0]    out_prio_q;
	logic                           out_empty_q;
	logic [bmpq_pkg::OUT_CNT_W-1:0] out_count_q;
	logic                           out_rej_q;

	logic                           ptr_below;
	logic                           shift_rd;
	logic                           scan_rd;
	logic                           take_new;
	logic                           take_scan;
	logic                           cnt_zero;
	logic [bmpq_pkg::CNT_EXT_W-1:0] count_ext;

	assign ptr_below = (ptr_q < count_q);
	assign shift_rd  = cmd.shift && ptr_below;
	assign scan_rd   = cmd.scan && ptr_below;
	assign cnt_zero  = (count_q == '0);
	assign count_ext = bmpq_pkg::CNT_EXT_W'(count_q);

	// newest entry wins only on a strictly higher priority
	assign take_new  = cnt_zero || (priority_req > head_prio_q);
	assign take_scan = cmp_pend_q &&
		((cmp_idx_q == '0) || (rd_data_q.prio > head_prio_q));

	assign status.empty      = cnt_zero;
	assign status.full       = (count_q == bmpq_pkg::CNT_W'(bmpq_pkg::DEPTH));
	assign status.shift_done = !ptr_below;
	assign status.scan_done  = !ptr_below && !cmp_pend_q;

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[ptr_q[bmpq_pkg::IDX_W-1:0]];
		if (cmd.ins)
			mem[count_q[bmpq_pkg::IDX_W-1:0]] <= '{prio: priority_req, tag: tag};
		else if (wr_pend_q)
			mem[wr_addr_q] <= rd_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ptr_q      <= '0;
			wr_pend_q  <= 1'b0;
			cmp_pend_q <= 1'b0;
		end else begin
			wr_pend_q  <= shift_rd;
			cmp_pend_q <= scan_rd;
			if (cmd.ins)
				count_q <= count_q + bmpq_pkg::CNT_W'(1);
			else if (cmd.clr)
				count_q <= '0;
			else if (cmd.shift_end)
				count_q <= count_q - bmpq_pkg::CNT_W'(1);

			if (cmd.shift_start)
				ptr_q <= bmpq_pkg::CNT_W'(head_idx_q) + bmpq_pkg::CNT_W'(1);
			else if (cmd.shift_end)
				ptr_q <= '0;
			else if (shift_rd || scan_rd)
				ptr_q <= ptr_q + bmpq_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= bmpq_pkg::IDX_W'(ptr_q - bmpq_pkg::CNT_W'(1));
		cmp_idx_q <= ptr_q[bmpq_pkg::IDX_W-1:0];
		if (cmd.accept)
			rej_q <= cmd.reject;

		if (cmd.ins && take_new) begin
			head_idx_q  <= count_q[bmpq_pkg::IDX_W-1:0];
			head_prio_q <= priority_req;
			head_tag_q  <= tag;
		end else if (take_scan) begin
			head_idx_q  <= cmp_idx_q;
			head_prio_q <= rd_data_q.prio;
			head_tag_q  <= rd_data_q.tag;
		end

		if (cmd.load_out) begin
			out_tag_q   <= cnt_zero ? '0 : head_tag_q;
			out_prio_q  <= cnt_zero ? '0 : head_prio_q;
			out_empty_q <= cnt_zero;
			out_count_q <= count_ext[bmpq_pkg::OUT_CNT_W-1:0];
			out_rej_q   <= rej_q;
		end
	end

	assign head_tag      = out_tag_q;
	assign head_priority = out_prio_q;
	assign is_empty      = out_empty_q;
	assign entry_count   = out_count_q;
	assign rejected      = out_rej_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bmpq_pkg::CNT_W'(bmpq_pkg::DEPTH))
		else $error("entry count above depth");

	a_write_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && wr_pend_q))
		else $error("insert collides with a shift write");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + bmpq_pkg::CNT_W'(1))
		else $error("insert did not advance the count");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		shift_rd |-> ptr_q != '0)
		else $error("shift read at slot zero");

endmodule

`default_nettype wire

>>> rtl/bounded_max_priority_queue_top.sv
// ----------------------------------------------------------------------------
// bounded_max_priority_queue_top
// Bounded max priority queue with oldest-first order among equal priorities.
// ----------------------------------------------------------------------------
// One item at a time: an item is taken only while the block is idle, and a
// finished result may sit stalled in the output register while the next item
// is taken. Insert, clear and query pass from acceptance through the done
// state into the output register (the head is kept up to date on insert).
// Remove from n entries runs two passes through the entry memory: the first
// moves the entries younger than the head down one slot, the second reads
// the n - 1 remaining entries to find the new head. A finished result waits
// in the done state for as long as an older result is still stalled in the
// output register. Entry storage needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_max_priority_queue_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [bmpq_pkg::MODE_W-1:0]        mode,
	input  wire logic [bmpq_pkg::DATA_W-1:0]        priority_req,
	input  wire logic [bmpq_pkg::DATA_W-1:0]        tag,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [bmpq_pkg::DATA_W-1:0]        head_tag,
	output logic      [bmpq_pkg::DATA_W-1:0]        head_priority,
	output logic                                    is_empty,
	output logic      [bmpq_pkg::OUT_CNT_W-1:0]     entry_count,
	output logic                                    rejected
);

	bmpq_pkg::cmd_t    cmd;
	bmpq_pkg::status_t status;

	bmpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bmpq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.priority_req  (priority_req),
		.tag           (tag),
		.cmd           (cmd),
		.status        (status),
		.head_tag      (head_tag),
		.head_priority (head_priority),
		.is_empty      (is_empty),
		.entry_count   (entry_count),
		.rejected      (rejected)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded max priority queue. A directed table
// covers the empty, tie and shift cases, then random insert/remove bursts
// fill the queue past full and drain it past empty. Every result is checked
// field by field against the table's own expected values or an in-bench
// queue predictor. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 850;
	localparam int TAIL_CYCLES = 2 * bmpq_pkg::DEPTH + 10;
	localparam int MAX_REPORTS = 200;

	typedef struct {
		logic [bmpq_pkg::DATA_W-1:0]    head_tag;
		logic [bmpq_pkg::DATA_W-1:0]    head_prio;
		logic                           empty;
		logic [bmpq_pkg::OUT_CNT_W-1:0] count;
		logic                           rej;
	} queue_status_t;

	typedef struct {
		bmpq_pkg::mode_t             op;
		logic [bmpq_pkg::DATA_W-1:0] prio;
		logic [bmpq_pkg::DATA_W-1:0] tg;
		bit                          typed;
		queue_status_t               res;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	bmpq_pkg::mode_t                mode = bmpq_pkg::MODE_QUERY;
	logic [bmpq_pkg::DATA_W-1:0]    priority_req = '0;
	logic [bmpq_pkg::DATA_W-1:0]    tag = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [bmpq_pkg::DATA_W-1:0]    head_tag;
	logic [bmpq_pkg::DATA_W-1:0]    head_priority;
	logic                           is_empty;
	logic [bmpq_pkg::OUT_CNT_W-1:0] entry_count;
	logic                           rejected;

	bounded_max_priority_queue_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.priority_req (priority_req),
		.tag          (tag),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.head_tag     (head_tag),
		.head_priority(head_priority),
		.is_empty     (is_empty),
		.entry_count  (entry_count),
		.rejected     (rejected)
	);

	always #5 clk = ~clk;

	// predicted queue contents, oldest entry at slot 0
	logic [bmpq_pkg::DATA_W-1:0] pq_prio [bmpq_pkg::DEPTH];
	logic [bmpq_pkg::DATA_W-1:0] pq_tag  [bmpq_pkg::DEPTH];
	int                          pq_count = 0;

	queue_status_t expected_q[$];
	stim_row_t     directed_rows[$];
	int            mismatch_count = 0;
	int            result_idx = 0;
	int            cycle_count = 0;
	int            items_sent = 0;
	int            stall_left = 0;
	int            stretch_left = 0;
	bit            tx_idle_on = 1'b1;
	bit            rx_idle_on = 1'b1;
	int            rx_wait;
	queue_status_t want;

	function automatic int pq_head_slot();
		int best;
		best = 0;
		for (int i = 1; i < pq_count; i++)
			if (pq_prio[i] > pq_prio[best])
				best = i;
		return best;
	endfunction

	function automatic queue_status_t pq_apply(bmpq_pkg::mode_t op,
			logic [bmpq_pkg::DATA_W-1:0] p, logic [bmpq_pkg::DATA_W-1:0] t);
		queue_status_t r;
		int h;
		r.rej = 1'b0;
		case (op)
			bmpq_pkg::MODE_INSERT: begin
				if (pq_count >= bmpq_pkg::DEPTH) begin
					r.rej = 1'b1;
				end else begin
					pq_prio[pq_count] = p;
					pq_tag[pq_count]  = t;
					pq_count++;
				end
			end
			bmpq_pkg::MODE_REMOVE: begin
				if (pq_count > 0) begin
					h = pq_head_slot();
					for (int i = h; i < pq_count - 1; i++) begin
						pq_prio[i] = pq_prio[i + 1];
						pq_tag[i]  = pq_tag[i + 1];
					end
					pq_count--;
				end
			end
			bmpq_pkg::MODE_CLEAR: pq_count = 0;
			default: ;
		endcase
		if (pq_count > 0) begin
			h = pq_head_slot();
			r.head_tag  = pq_tag[h];
			r.head_prio = pq_prio[h];
			r.empty     = 1'b0;
		end else begin
			r.head_tag  = '0;
			r.head_prio = '0;
			r.empty     = 1'b1;
		end
		r.count = bmpq_pkg::OUT_CNT_W'(pq_count);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		// keep the log bounded when everything goes wrong
		if (mismatch_count < MAX_REPORTS)
			$display("ERROR @%0t result %0d: %s", $time, result_idx, msg);
		mismatch_count++;
	endtask

	function automatic void add_row(bmpq_pkg::mode_t op, logic [bmpq_pkg::DATA_W-1:0] p,
			logic [bmpq_pkg::DATA_W-1:0] t, bit typed,
			logic [bmpq_pkg::DATA_W-1:0] ht = '0, logic [bmpq_pkg::DATA_W-1:0] hp = '0,
			logic em = 1'b1, int cnt = 0, logic rj = 1'b0);
		stim_row_t row;
		row.op            = op;
		row.prio          = p;
		row.tg            = t;
		row.typed         = typed;
		row.res.head_tag  = ht;
		row.res.head_prio = hp;
		row.res.empty     = em;
		row.res.count     = bmpq_pkg::OUT_CNT_W'(cnt);
		row.res.rej       = rj;
		directed_rows = {directed_rows, row};
	endfunction

	function automatic logic [bmpq_pkg::DATA_W-1:0] pick_prio();
		case ($urandom_range(0, 3))
			0: return bmpq_pkg::DATA_W'($urandom_range(0, 3)); // dense ties
			1: return $urandom_range(0, 1) ? '1 : '0;
			default: return bmpq_pkg::DATA_W'($urandom());
		endcase
	endfunction

	// Drive one item and hold it until taken; the expectation is queued at
	// the accepting edge, then the sender idles for a random gap.
	task automatic send_item(input stim_row_t row);
		queue_status_t r;
		int gap;
		mode         <= row.op;
		priority_req <= row.prio;
		tag          <= row.tg;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		r = pq_apply(row.op, row.prio, row.tg);
		expected_q = {expected_q, (row.typed ? row.res : r)};
		items_sent++;
		if (stretch_left == 0) begin
			stretch_left = $urandom_range(20, 60);
			tx_idle_on   = ($urandom_range(0, 2) != 0);
			rx_idle_on   = ($urandom_range(0, 2) != 0);
		end
		stretch_left--;
		gap = tx_idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_rand(input bmpq_pkg::mode_t op);
		stim_row_t row;
		row.op    = op;
		row.prio  = pick_prio();
		row.tg    = bmpq_pkg::DATA_W'($urandom());
		row.typed = 1'b0;
		row.res   = '{default: '0};
		send_item(row);
	endtask

	// hold off new items until every outstanding result has come back
	task automatic drain_pause();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	// result checking and receiver stall
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result tag %h prio %h",
					head_tag, head_priority));
			end else begin
				want = expected_q.pop_front();
				if (head_tag !== want.head_tag)
					report_mismatch($sformatf("head_tag %h, want %h", head_tag, want.head_tag));
				if (head_priority !== want.head_prio)
					report_mismatch($sformatf("head_priority %h, want %h",
						head_priority, want.head_prio));
				if (is_empty !== want.empty)
					report_mismatch($sformatf("is_empty %b, want %b", is_empty, want.empty));
				if (entry_count !== want.count)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						entry_count, want.count));
				if (rejected !== want.rej)
					report_mismatch($sformatf("rejected %b, want %b", rejected, want.rej));
			end
			result_idx++;
			rx_wait    = rx_idle_on ? $urandom_range(0, 12) : 0;
			stall_left = rx_wait;
			out_stall <= (rx_wait != 0);
		end else if (out_valid === 1'b1 && out_stall) begin
			stall_left--;
			if (stall_left <= 0)
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		int n;
		int target;

		// empty queue, ignored fields, ties and a head in the middle
		add_row(bmpq_pkg::MODE_QUERY,  16'h0000, 16'h0000, 1'b1);
		add_row(bmpq_pkg::MODE_REMOVE, 16'hFFFF, 16'hFFFF, 1'b1);
		add_row(bmpq_pkg::MODE_CLEAR,  16'hFFFF, 16'hFFFF, 1'b1);
		add_row(bmpq_pkg::MODE_INSERT, 16'h0000, 16'h0000, 1'b1,
			16'h0000, 16'h0000, 1'b0, 1);
		add_row(bmpq_pkg::MODE_INSERT, 16'hFFFF, 16'hFFFF, 1'b1,
			16'hFFFF, 16'hFFFF, 1'b0, 2);
		add_row(bmpq_pkg::MODE_INSERT, 16'hFFFF, 16'h1234, 1'b1,
			16'hFFFF, 16'hFFFF, 1'b0, 3);
		add_row(bmpq_pkg::MODE_QUERY,  16'h1111, 16'h2222, 1'b1,
			16'hFFFF, 16'hFFFF, 1'b0, 3);
		add_row(bmpq_pkg::MODE_REMOVE, 16'h0000, 16'h0000, 1'b1,
			16'h1234, 16'hFFFF, 1'b0, 2);
		add_row(bmpq_pkg::MODE_INSERT, 16'h8000, 16'h00AA, 1'b0);
		add_row(bmpq_pkg::MODE_INSERT, 16'h8000, 16'h00BB, 1'b0);
		add_row(bmpq_pkg::MODE_REMOVE, 16'h5A5A, 16'hA5A5, 1'b1,
			16'h00AA, 16'h8000, 1'b0, 3);
		add_row(bmpq_pkg::MODE_REMOVE, 16'h0000, 16'h0000, 1'b0);
		add_row(bmpq_pkg::MODE_REMOVE, 16'h0000, 16'h0000, 1'b1,
			16'h0000, 16'h0000, 1'b0, 1);
		add_row(bmpq_pkg::MODE_REMOVE, 16'h0000, 16'h0000, 1'b1);
		add_row(bmpq_pkg::MODE_REMOVE, 16'hFFFF, 16'h0000, 1'b1);
		add_row(bmpq_pkg::MODE_INSERT, 16'h5555, 16'hAAAA, 1'b0);
		add_row(bmpq_pkg::MODE_INSERT, 16'hAAAA, 16'h5555, 1'b0);
		add_row(bmpq_pkg::MODE_QUERY,  16'h0000, 16'hFFFF, 1'b0);
		add_row(bmpq_pkg::MODE_CLEAR,  16'h0000, 16'h0000, 1'b1);
		add_row(bmpq_pkg::MODE_INSERT, 16'h0001, 16'hFFFF, 1'b0);
		add_row(bmpq_pkg::MODE_QUERY,  16'hFFFF, 16'h0000, 1'b0);
		add_row(bmpq_pkg::MODE_REMOVE, 16'h0000, 16'h0000, 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i]);
		drain_pause();

		target = items_sent + RAND_ITEMS;
		while (items_sent < target) begin
			case ($urandom_range(0, 3))
				0: begin
					// fill past full so some inserts bounce
					n = bmpq_pkg::DEPTH - pq_count + $urandom_range(0, 3);
					repeat (n) send_rand(bmpq_pkg::MODE_INSERT);
				end
				1: begin
					// drain past empty
					n = pq_count + $urandom_range(0, 2);
					repeat (n) send_rand(bmpq_pkg::MODE_REMOVE);
				end
				default: begin
					n = $urandom_range(10, 40);
					repeat (n) begin
						case ($urandom_range(0, 19))
							0: send_rand(bmpq_pkg::MODE_CLEAR);
							1, 2, 3: send_rand(bmpq_pkg::MODE_QUERY);
							4, 5, 6, 7, 8, 9: send_rand(bmpq_pkg::MODE_REMOVE);
							default: send_rand(bmpq_pkg::MODE_INSERT);
						endcase
					end
				end
			endcase
			if ($urandom_range(0, 24) == 0)
				drain_pause();
		end

		drain_pause();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/bmpq_pkg.sv
rtl/bmpq_ctrl.sv
rtl/bmpq_dp.sv
rtl/bounded_max_priority_queue_top.sv
tb/sv/tb_top.sv
